@@ hdl/mflw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mflw_pkg;

   localparam int MaxWidth  = 1024;
   localparam int MaxHeight = 1024;
   localparam int MaxWindow = 7;

   localparam int DimW   = 11;
   localparam int ColW   = $clog2(MaxWidth);
   localparam int RowW   = $clog2(MaxHeight);
   localparam int SlotW  = $clog2(MaxWindow);
   localparam int SizeW  = 3;
   localparam int CntW   = ColW + RowW + 1;
   localparam int PixW   = 24;
   localparam int Depth  = MaxWindow * MaxWidth;
   localparam int AddrW  = SlotW + ColW;
   localparam int CellN  = MaxWindow * MaxWindow;

   typedef enum logic [1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_WINDOW_SIZE  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic       func;
      logic [7:0] luma_in;
      logic [7:0] cb_in;
      logic [7:0] cr_in;
   } req_type;

   typedef struct packed {
      logic [7:0] luma_out;
      logic [7:0] cb_out;
      logic [7:0] cr_out;
      logic       frame_end;
   } rsp_type;

   typedef struct packed {
      logic take;
      logic center;
      logic gather;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic emit_now;
      logic interior;
      logic gather_last;
      logic rsp_free;
   } dp_stat_type;

endpackage

`default_nettype wire

@@ hdl/median_filter_luma_window.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Streaming 2-D median filter on the luma of a raster-order YUV frame. Each
// pixel transfer is written into a seven-row line store; once enough rows are
// in, every pixel transfer releases one result, lagging the input by r*W + r
// pixels (r = window_size/2), and flush transfers drain the tail after the
// last pixel. Interior pixels get the median of the s*s window lumas (the
// upper median for even s); border pixels and all chroma pass unchanged.
// frame_end marks the frame's last result and rearms the block for the next
// frame. A write to any of the three registers restarts the frame. A transfer
// that yields no result needs only the idle state; a border result passes the
// center, drain and finish states, and an interior result also gathers the s*s
// window from the single read port of the line store, one pixel per cycle,
// into an insertion-sort array. A finished result waits in an output register.

module median_filter_luma_window (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire mflw_pkg::req_type         req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output mflw_pkg::rsp_type              rsp_data,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [1:0]                csr_index,
   input  wire logic [mflw_pkg::DimW-1:0] csr_data
);

   import mflw_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   assign csr_ready = 1'b1;

   mflw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mflw_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

@@ hdl/mflw_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mflw_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ hdl/mflw_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mflw_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire mflw_pkg::dp_stat_type stat,
   output mflw_pkg::dp_cmd_type      cmd
);

   import mflw_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CENTER,
      S_GATHER,
      S_DRAIN,
      S_FINISH
   } state_type;

   state_type state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid && stat.emit_now) state_ff <= S_CENTER;
            end
            S_CENTER: state_ff <= stat.interior ? S_GATHER : S_DRAIN;
            S_GATHER: begin
               if (stat.gather_last) state_ff <= S_DRAIN;
            end
            S_DRAIN:  state_ff <= S_FINISH;
            S_FINISH: begin
               if (stat.rsp_free) state_ff <= S_IDLE;
            end
            default:  state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      req_ready  = (state_ff == S_IDLE);
      cmd.take   = req_valid && (state_ff == S_IDLE);
      cmd.center = (state_ff == S_CENTER);
      cmd.gather = (state_ff == S_GATHER);
      cmd.finish = (state_ff == S_FINISH) && stat.rsp_free;
   end

endmodule

`default_nettype wire

@@ hdl/mflw_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mflw_datapath (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire mflw_pkg::req_type      req_data,
   input  wire logic                   csr_valid,
   input  wire logic [1:0]             csr_index,
   input  wire logic [mflw_pkg::DimW-1:0] csr_data,
   input  wire mflw_pkg::dp_cmd_type   cmd,
   output mflw_pkg::dp_stat_type       stat,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output mflw_pkg::rsp_type           rsp_data
);

   import mflw_pkg::*;

   localparam logic [SlotW-1:0] SlotLast = SlotW'(MaxWindow - 1);

   // configuration
   logic [DimW-1:0]  width_ff, height_ff;
   logic [SizeW-1:0] size_ff;
   logic [DimW-1:0]  w_eff, h_eff;
   logic [SizeW-1:0] s_eff;
   logic [1:0]       rad;
   logic [CntW-1:0]  lag;
   logic [5:0]       med_idx;

   // position state
   logic [ColW-1:0]  in_col_ff, out_col_ff;
   logic [RowW-1:0]  in_row_ff, out_row_ff;
   logic [SlotW-1:0] in_slot_ff, out_slot_ff;
   logic [CntW-1:0]  recv_ff, done_ff;
   logic             draining_ff;

   // window walk
   logic [SizeW-1:0] ga_ff, gb_ff;
   logic [SlotW-1:0] gslot_ff;
   logic [ColW-1:0]  gcol_ff, gcol0_ff;
   logic [SlotW:0]   gslot_sum;
   logic             rd_center_ff, rd_win_ff;

   logic [PixW-1:0]  center_ff;
   logic [7:0]       cells_ff [CellN];
   logic [7:0]       cells_in [CellN];
   logic [7:0]       v;

   logic             restart, pix_take, last;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   logic             ram_we;
   logic [AddrW-1:0] ram_waddr, ram_raddr;
   logic [PixW-1:0]  ram_wdata, ram_rdata;

   always_comb begin
      w_eff = width_ff;
      if (width_ff == '0) w_eff = DimW'(1);
      else if (width_ff > DimW'(MaxWidth)) w_eff = DimW'(MaxWidth);
      h_eff = height_ff;
      if (height_ff == '0) h_eff = DimW'(1);
      else if (height_ff > DimW'(MaxHeight)) h_eff = DimW'(MaxHeight);
      s_eff = (size_ff == '0) ? SizeW'(1) : size_ff;
      rad   = s_eff[2:1];
      lag   = (rad[1] ? CntW'({w_eff, 1'b0}) : '0) + (rad[0] ? CntW'(w_eff) : '0)
            + CntW'(rad);
      case (s_eff)
         3'd2:    med_idx = 6'd2;
         3'd3:    med_idx = 6'd4;
         3'd4:    med_idx = 6'd8;
         3'd5:    med_idx = 6'd12;
         3'd6:    med_idx = 6'd18;
         3'd7:    med_idx = 6'd24;
         default: med_idx = 6'd0;
      endcase
   end

   always_comb begin
      pix_take = cmd.take && !req_data.func && !draining_ff;
      last     = ({1'b0, out_row_ff} == h_eff - DimW'(1))
              && ({1'b0, out_col_ff} == w_eff - DimW'(1));
      restart  = 1'b0;
      if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_WIDTH, CSR_FRAME_HEIGHT, CSR_WINDOW_SIZE: restart = 1'b1;
            default: restart = 1'b0;
         endcase
      end
      if (cmd.finish && last) restart = 1'b1;

      stat.emit_now    = req_data.func ? draining_ff
                       : (!draining_ff && ((recv_ff + CntW'(1) - done_ff) > lag));
      stat.interior    = ({1'b0, out_row_ff} >= DimW'(rad))
                      && ({1'b0, out_row_ff} + DimW'(rad) <= h_eff - DimW'(1))
                      && ({1'b0, out_col_ff} >= DimW'(rad))
                      && ({1'b0, out_col_ff} + DimW'(rad) <= w_eff - DimW'(1));
      stat.gather_last = (ga_ff == s_eff - SizeW'(1)) && (gb_ff == s_eff - SizeW'(1));
      stat.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DimW'(512);
         height_ff <= DimW'(512);
         size_ff   <= SizeW'(3);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  width_ff  <= csr_data;
            CSR_FRAME_HEIGHT: height_ff <= csr_data;
            CSR_WINDOW_SIZE:  size_ff   <= csr_data[SizeW-1:0];
            default: ;
         endcase
      end
   end

   // frame position counters
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_slot_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_slot_ff <= '0;
         recv_ff     <= '0;
         done_ff     <= '0;
         draining_ff <= 1'b0;
      end else begin
         if (pix_take) begin
            recv_ff <= recv_ff + CntW'(1);
            if ({1'b0, in_col_ff} + DimW'(1) >= w_eff) begin
               in_col_ff <= '0;
               if ({1'b0, in_row_ff} + DimW'(1) >= h_eff) begin
                  in_row_ff   <= '0;
                  in_slot_ff  <= '0;
                  draining_ff <= 1'b1;
               end else begin
                  in_row_ff  <= in_row_ff + RowW'(1);
                  in_slot_ff <= (in_slot_ff == SlotLast) ? '0 : in_slot_ff + SlotW'(1);
               end
            end else begin
               in_col_ff <= in_col_ff + ColW'(1);
            end
         end
         if (cmd.finish) begin
            done_ff <= done_ff + CntW'(1);
            if ({1'b0, out_col_ff} + DimW'(1) >= w_eff) begin
               out_col_ff  <= '0;
               out_row_ff  <= out_row_ff + RowW'(1);
               out_slot_ff <= (out_slot_ff == SlotLast) ? '0 : out_slot_ff + SlotW'(1);
            end else begin
               out_col_ff <= out_col_ff + ColW'(1);
            end
         end
      end
   end

   // window address walk
   always_comb begin
      gslot_sum = {1'b0, out_slot_ff} + (SlotW+1)'(MaxWindow) - (SlotW+1)'(rad);
      if (gslot_sum >= (SlotW+1)'(MaxWindow)) begin
         gslot_sum = gslot_sum - (SlotW+1)'(MaxWindow);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_center_ff <= 1'b0;
         rd_win_ff    <= 1'b0;
      end else begin
         rd_center_ff <= cmd.center;
         rd_win_ff    <= cmd.gather;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.center) begin
         ga_ff    <= '0;
         gb_ff    <= '0;
         gslot_ff <= gslot_sum[SlotW-1:0];
         gcol_ff  <= out_col_ff - ColW'(rad);
         gcol0_ff <= out_col_ff - ColW'(rad);
      end else if (cmd.gather) begin
         if (gb_ff == s_eff - SizeW'(1)) begin
            gb_ff    <= '0;
            ga_ff    <= ga_ff + SizeW'(1);
            gcol_ff  <= gcol0_ff;
            gslot_ff <= (gslot_ff == SlotLast) ? '0 : gslot_ff + SlotW'(1);
         end else begin
            gb_ff   <= gb_ff + SizeW'(1);
            gcol_ff <= gcol_ff + ColW'(1);
         end
      end
   end

   always_comb begin
      ram_we    = pix_take;
      ram_waddr = {in_slot_ff, in_col_ff};
      ram_wdata = {req_data.cr_in, req_data.cb_in, req_data.luma_in};
      ram_raddr = cmd.center ? {out_slot_ff, out_col_ff} : {gslot_ff, gcol_ff};
   end

   mflw_ram #(
      .Width (PixW),
      .Depth (Depth)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // sorted insertion: each cell keeps, takes the new value, or shifts up
   always_comb begin
      v = ram_rdata[7:0];
      for (int i = 0; i < CellN; i++) begin
         if (i > 0 && cells_ff[(i > 0) ? i - 1 : 0] > v) begin
            cells_in[i] = cells_ff[(i > 0) ? i - 1 : 0];
         end else if (cells_ff[i] > v) begin
            cells_in[i] = v;
         end else begin
            cells_in[i] = cells_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CellN; i++) begin
         if (cmd.center) cells_ff[i] <= 8'hFF;
         else if (rd_win_ff) cells_ff[i] <= cells_in[i];
      end
      if (rd_center_ff) center_ff <= ram_rdata;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_data_ff.luma_out  <= stat.interior ? cells_ff[med_idx] : center_ff[7:0];
         rsp_data_ff.cb_out    <= center_ff[15:8];
         rsp_data_ff.cr_out    <= center_ff[23:16];
         rsp_data_ff.frame_end <= last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
